/* hdl/ipv4_tcp_receive_filter_top_defines.svh */
// Assertion macros for the IPv4 receive filter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef IPV4_TCP_RECEIVE_FILTER_TOP_DEFINES_SVH
`define IPV4_TCP_RECEIVE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ITRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itrf: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ITRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itrf: next-cycle check failed");

`endif

/* hdl/itrf_pkg.sv */
// Shared types and constants for the IPv4 receive filter.
// No dependencies.
`default_nettype none
package itrf_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 65536;
  localparam int MIN_HDR_BYTES        = 20;
  localparam int ADDR_FIRST           = 12;
  localparam int ADDR_END             = 20;
  localparam logic [7:0] PROTO_RESET  = 8'd6;
  localparam logic [3:0] VERSION_V4   = 4'd4;
  localparam logic [15:0] LEN_EXTRA   = 16'd8;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL = 3'd1;
  localparam logic [2:0] ST_NOT_V4    = 3'd2;
  localparam logic [2:0] ST_BAD_PROTO = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
  localparam logic [2:0] ST_HDR_LONG  = 3'd5;
  localparam logic [2:0] ST_BAD_IHL   = 3'd6;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_status;
    logic [2:0]  status_code;
    logic [15:0] out_length;
  } res_t;

  typedef struct packed {
    logic p0;
    logic p1;
    res_t item0;
    res_t item1;
  } push_t;

endpackage
`default_nettype wire

/* hdl/itrf_parse.sv */
// Per-byte header tracking, forwarding decision and end-of-packet verdict.
// Depends on itrf_pkg.
`default_nettype none
module itrf_parse #(
  parameter int MAX_PACKET_BYTES = itrf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          in_fire,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output itrf_pkg::push_t    push
);

  localparam int CW   = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CMPW = (CW > 16) ? CW : 16;

  logic [7:0]    proto_r;
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [3:0]    header_words_r, header_words_nxt;
  logic [15:0]   declared_length_r, declared_length_nxt;
  logic          version_good_r, version_good_nxt;
  logic          protocol_good_r, protocol_good_nxt;

  logic            sat;
  logic [CW-1:0]   size;
  logic [5:0]      hl;
  logic            addr_hit, pay_hit, fwd;
  logic [CMPW-1:0] size_x, total_x;
  logic [2:0]      code;
  logic [15:0]     len;

  always_comb begin
    sat                 = byte_count_r >= CW'(MAX_PACKET_BYTES);
    hl                  = {header_words_r, 2'b00};
    header_words_nxt    = header_words_r;
    declared_length_nxt = declared_length_r;
    version_good_nxt    = version_good_r;
    protocol_good_nxt   = protocol_good_r;
    if (!sat) begin
      case (byte_count_r)
        CW'(0): begin
          header_words_nxt = data_byte[3:0];
          version_good_nxt = data_byte[7:4] == itrf_pkg::VERSION_V4;
        end
        CW'(2): declared_length_nxt = {data_byte, declared_length_r[7:0]};
        CW'(3): declared_length_nxt = {declared_length_r[15:8], data_byte};
        CW'(9): protocol_good_nxt = data_byte == proto_r;
        default: ;
      endcase
    end
    size     = sat ? byte_count_r : byte_count_r + CW'(1);
    addr_hit = byte_count_r >= CW'(itrf_pkg::ADDR_FIRST) &&
               byte_count_r <  CW'(itrf_pkg::ADDR_END);
    pay_hit  = byte_count_r >= CW'(itrf_pkg::MIN_HDR_BYTES) &&
               byte_count_r >= CW'(hl);
    fwd      = !sat && version_good_nxt && protocol_good_nxt && (addr_hit || pay_hit);

    size_x  = CMPW'(size);
    total_x = CMPW'(declared_length_nxt);
    len     = '0;
    if (size < CW'(itrf_pkg::MIN_HDR_BYTES)) begin
      code = itrf_pkg::ST_TOO_SMALL;
    end else if (!version_good_nxt) begin
      code = itrf_pkg::ST_NOT_V4;
    end else if (!protocol_good_nxt) begin
      code = itrf_pkg::ST_BAD_PROTO;
    end else if ({header_words_nxt, 2'b00} < 6'(itrf_pkg::MIN_HDR_BYTES)) begin
      code = itrf_pkg::ST_BAD_IHL;
    end else if (total_x != size_x) begin
      code = itrf_pkg::ST_BAD_SIZE;
    end else if (16'({header_words_nxt, 2'b00}) > declared_length_nxt) begin
      code = itrf_pkg::ST_HDR_LONG;
    end else begin
      code = itrf_pkg::ST_OK;
      len  = declared_length_nxt - 16'({header_words_nxt, 2'b00}) + itrf_pkg::LEN_EXTRA;
    end

    byte_count_nxt = size;
    if (last_byte) begin
      byte_count_nxt      = '0;
      header_words_nxt    = '0;
      declared_length_nxt = '0;
      version_good_nxt    = 1'b0;
      protocol_good_nxt   = 1'b0;
    end
  end

  // Status goes in the first slot when no data byte is forwarded.
  always_comb begin
    itrf_pkg::res_t d_item, s_item;
    d_item = '{out_byte: data_byte, is_status: 1'b0, status_code: itrf_pkg::ST_OK,
               out_length: 16'd0};
    s_item = '{out_byte: 8'd0, is_status: 1'b1, status_code: code, out_length: len};
    push.p0    = in_fire && (fwd || last_byte);
    push.p1    = in_fire && fwd && last_byte;
    push.item0 = fwd ? d_item : s_item;
    push.item1 = s_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r           <= itrf_pkg::PROTO_RESET;
      byte_count_r      <= '0;
      header_words_r    <= '0;
      declared_length_r <= '0;
      version_good_r    <= 1'b0;
      protocol_good_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        proto_r <= cfg_data;
      end
      if (in_fire) begin
        byte_count_r      <= byte_count_nxt;
        header_words_r    <= header_words_nxt;
        declared_length_r <= declared_length_nxt;
        version_good_r    <= version_good_nxt;
        protocol_good_r   <= protocol_good_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/itrf_outq.sv */
// Result queue: takes up to two result items per cycle, hands out one per transfer.
// Depends on itrf_pkg and the assertion macro header.
`default_nettype none
`include "ipv4_tcp_receive_filter_top_defines.svh"
module itrf_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire itrf_pkg::push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output itrf_pkg::res_t       out_item
);

  itrf_pkg::res_t mem_r [itrf_pkg::QDEPTH];
  logic [itrf_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [itrf_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic                     pop;
  logic [itrf_pkg::QAW:0]   n_push;

  assign room      = cnt_r <= (itrf_pkg::QAW+1)'(itrf_pkg::QDEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = (itrf_pkg::QAW+1)'(push.p0) + (itrf_pkg::QAW+1)'(push.p1);
  assign cnt_nxt   = cnt_r + n_push - (itrf_pkg::QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.p0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.p1) begin
      mem_r[wr_ptr_r + itrf_pkg::QAW'(1)] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push[itrf_pkg::QAW-1:0];
      rd_ptr_r <= rd_ptr_r + itrf_pkg::QAW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  `ITRF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (itrf_pkg::QAW+1)'(itrf_pkg::QDEPTH))
  `ITRF_ASSERT_NOW(a_push_order, push.p1, push.p0 && push.item1.is_status)
  `ITRF_ASSERT_NEXT(a_hold_head, out_valid && !out_ready && !push.p0, $stable(out_item))

endmodule
`default_nettype wire

/* hdl/ipv4_tcp_receive_filter_top.sv */
// IPv4 receive filter: forwards addresses and payload of matching packets
// and reports a verdict per packet. Depends on itrf_pkg, itrf_parse, itrf_outq.
//
// Usage:
//   in_*  : one packet byte per transfer in in_tdata, in_tlast on the final byte.
//   out_* : out_tuser = 0 for an address/payload byte, 1 for the status item
//           that follows the final byte. out_tdata carries byte, code, length.
//   cfg_* : writes the accepted protocol number (reset value 6, TCP).
// Each result item is registered in the result queue and is presented once it reaches the head.
// Throughput: one byte per cycle while in_tready is high; a final byte that is also
//   forwarded yields two items, which the four-entry result queue absorbs.
// in_tready depends only on queue fill, never combinationally on out_tready.
// When the receiver stalls, the queue fills and in_tready drops once fewer
//   than two entries are free; items are held, none are dropped.
// Reset (synchronous, rst_n low) empties the queue, clears the per-packet
//   state and restores the protocol register. No clearing pass is needed.
// Bytes beyond MAX_PACKET_BYTES in one packet are ignored except for in_tlast.
`default_nettype none
module ipv4_tcp_receive_filter_top #(
  parameter int MAX_PACKET_BYTES = itrf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,    // [7:0] accepted_protocol
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [7:0] out_byte, [10:8] status_code,
                                        // [26:11] out_length, [31:27] zero
  output logic             out_tuser    // [0] is_status
);

  itrf_pkg::push_t push;
  itrf_pkg::res_t  head;
  logic            room;
  logic            in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign in_fire   = in_tvalid && room;

  itrf_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .data_byte(in_tdata),
    .last_byte(in_tlast),
    .push     (push)
  );

  itrf_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (head)
  );

  assign out_tdata = {5'd0, head.out_length, head.status_code, head.out_byte};
  assign out_tuser = head.is_status;

endmodule
`default_nettype wire

/* test/ipv4_tcp_receive_filter_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_tcp_receive_filter_top: drives IPv4 packets byte by byte,
// predicts forwarded address/payload bytes and the end-of-packet verdict, checks every result.
// Depends on itrf_pkg and the filter RTL only.
module ipv4_tcp_receive_filter_top_tb;

  localparam int OFS_VER_IHL = 0;
  localparam int OFS_LEN_HI  = 2;
  localparam int OFS_LEN_LO  = 3;
  localparam int OFS_PROTO   = 9;
  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BYTES = 20;

  typedef logic [7:0] byte_q_t[$];
  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  class filter_scoreboard;
    itrf_pkg::res_t pending_items[$];
    logic [7:0]  protocol;
    logic [16:0] byte_count;
    logic [3:0]  header_words;
    logic [15:0] declared_length;
    bit          version_good;
    bit          protocol_good;
    int unsigned errors;
    int unsigned checked;
    int unsigned code_seen[7];

    function void clear_packet();
      byte_count = '0;
      header_words = '0;
      declared_length = '0;
      version_good = 0;
      protocol_good = 0;
    endfunction

    function void power_on();
      protocol = itrf_pkg::PROTO_RESET;
      pending_items.delete();
      clear_packet();
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      itrf_pkg::res_t r;
      int unsigned pos;
      int unsigned hl;
      int unsigned size;
      if (byte_count < itrf_pkg::MAX_PACKET_BYTES_DEF) begin
        pos = byte_count;
        hl = header_words * 4;
        case (pos)
          OFS_VER_IHL: begin
            header_words = b[3:0];
            version_good = b[7:4] == itrf_pkg::VERSION_V4;
          end
          OFS_LEN_HI: declared_length[15:8] = b;
          OFS_LEN_LO: declared_length[7:0] = b;
          OFS_PROTO: protocol_good = b == protocol;
          default: ;
        endcase
        if (version_good && protocol_good &&
            ((pos >= itrf_pkg::ADDR_FIRST && pos < itrf_pkg::ADDR_END) ||
             (pos >= itrf_pkg::MIN_HDR_BYTES && pos >= hl))) begin
          r = '0;
          r.out_byte = b;
          pending_items.push_back(r);
        end
        byte_count = 17'(pos + 1);
      end
      if (last) begin
        size = byte_count;
        hl = header_words * 4;
        r = '0;
        r.is_status = 1'b1;
        if (size < itrf_pkg::MIN_HDR_BYTES) r.status_code = itrf_pkg::ST_TOO_SMALL;
        else if (!version_good) r.status_code = itrf_pkg::ST_NOT_V4;
        else if (!protocol_good) r.status_code = itrf_pkg::ST_BAD_PROTO;
        else if (hl < itrf_pkg::MIN_HDR_BYTES) r.status_code = itrf_pkg::ST_BAD_IHL;
        else if (declared_length != size) r.status_code = itrf_pkg::ST_BAD_SIZE;
        else if (hl > declared_length) r.status_code = itrf_pkg::ST_HDR_LONG;
        else begin
          r.status_code = itrf_pkg::ST_OK;
          r.out_length = 16'(declared_length - hl + itrf_pkg::LEN_EXTRA);
        end
        pending_items.push_back(r);
        clear_packet();
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
    endtask

    task match_item(logic [31:0] data, logic user);
      itrf_pkg::res_t want;
      if (pending_items.size() == 0) begin
        report($sformatf("unexpected transfer tdata=%h tuser=%b", data, user));
        return;
      end
      want = pending_items.pop_front();
      checked++;
      if (data[7:0] !== want.out_byte)
        report($sformatf("byte %h, want %h", data[7:0], want.out_byte));
      if (user !== want.is_status)
        report($sformatf("is_status %b, want %b", user, want.is_status));
      if (data[10:8] !== want.status_code)
        report($sformatf("status %0d, want %0d", data[10:8], want.status_code));
      if (data[26:11] !== want.out_length)
        report($sformatf("length %0d, want %0d", data[26:11], want.out_length));
      if (data[31:27] !== '0)
        report($sformatf("pad bits %b not zero", data[31:27]));
      if (want.is_status) code_seen[want.status_code]++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;   // [7:0] out_byte, [10:8] status_code, [26:11] out_length
  logic        out_tuser;   // [0] is_status

  filter_scoreboard sb = new;
  rx_mode_t    rx_mode = RX_ALWAYS;
  bit          long_hold = 1'b0;
  bit          tx_gaps = 1'b0;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned settings_used = 0;
  int unsigned quiet = 0;

  ipv4_tcp_receive_filter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.match_item(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.take_byte(in_tdata, in_tlast);
      if (cfg_valid && cfg_ready) sb.protocol = cfg_data;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0] pattern;
    pattern = 8'b1011_0110;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_RANDOM: out_tready <= $urandom_range(0, 3) != 0;
          default: begin
            out_tready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  function automatic byte_q_t make_packet(logic [3:0] ver, logic [3:0] ihl, logic [7:0] proto,
                                          int unsigned size, logic [15:0] decl);
    byte_q_t pkt;
    for (int i = 0; i < size; i++) pkt.push_back(8'($urandom_range(0, 255)));
    if (size > OFS_VER_IHL) pkt[OFS_VER_IHL] = {ver, ihl};
    if (size > OFS_LEN_HI) pkt[OFS_LEN_HI] = decl[15:8];
    if (size > OFS_LEN_LO) pkt[OFS_LEN_LO] = decl[7:0];
    if (size > OFS_PROTO) pkt[OFS_PROTO] = proto;
    return pkt;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_gaps && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    bytes_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_range(input byte_q_t pkt, input int lo, input int hi);
    for (int i = lo; i < hi; i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic send_packet(input byte_q_t pkt);
    send_range(pkt, 0, pkt.size());
    packets_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_protocol(input logic [7:0] p);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_packet(input logic [7:0] p);
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] decl;
    int unsigned size;
    ver = itrf_pkg::VERSION_V4;
    proto = p;
    ihl = 4'($urandom_range(5, 8));
    if ($urandom_range(0, 9) == 0) ihl = 4'($urandom_range(9, 15));
    size = ihl * 4 + $urandom_range(0, 16);
    decl = 16'(size);
    if ($urandom_range(0, 99) >= 75) begin
      case ($urandom_range(0, 6))
        0: do ver = 4'($urandom); while (ver == itrf_pkg::VERSION_V4);
        1: proto = p ^ 8'($urandom_range(1, 255));
        2: begin
          ihl = 4'($urandom_range(0, 4));
          size = $urandom_range(20, 40);
          decl = 16'(size);
        end
        3: decl = 16'($urandom);
        4: begin
          size = $urandom_range(1, 19);
          decl = 16'(size);
        end
        5: begin
          ihl = 4'd15;
          size = $urandom_range(20, 59);
          decl = 16'(size);
        end
        default: begin
          ver = 4'($urandom);
          ihl = 4'($urandom);
          proto = 8'($urandom);
          size = $urandom_range(1, 40);
          decl = 16'($urandom_range(1, 40));
        end
      endcase
    end
    send_packet(make_packet(ver, ihl, proto, size, decl));
  endtask

  initial begin
    byte_q_t     pkt;
    logic [7:0]  setting;
    int unsigned start;
    sb.power_on();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rx_mode = RX_PATTERN;
    tx_gaps = 1'b1;
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, itrf_pkg::PROTO_RESET, 28, 16'd28));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, itrf_pkg::PROTO_RESET, 1, 16'd1));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, itrf_pkg::PROTO_RESET, 19, 16'd19));
    send_packet(make_packet(4'd6, 4'd5, itrf_pkg::PROTO_RESET, 20, 16'd20));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, 8'd17, 24, 16'd24));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd3, itrf_pkg::PROTO_RESET, 24, 16'd24));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd0, itrf_pkg::PROTO_RESET, 20, 16'd20));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, itrf_pkg::PROTO_RESET, 30, 16'd100));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd15, itrf_pkg::PROTO_RESET, 40, 16'd40));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd15, itrf_pkg::PROTO_RESET, 64, 16'd64));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, itrf_pkg::PROTO_RESET, 20, 16'd20));

    rx_mode = RX_RANDOM;
    write_protocol(8'd0);
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, 8'd0, 26, 16'd26));
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, itrf_pkg::PROTO_RESET, 26, 16'd26));
    write_protocol(8'd255);
    send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd6, 8'd255, 33, 16'd33));

    pkt = make_packet(itrf_pkg::VERSION_V4, 4'd5, 8'd17, 32, 16'd32);
    send_range(pkt, 0, 6);
    write_protocol(8'd17);
    send_range(pkt, 6, pkt.size());
    packets_sent++;

    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    write_protocol(itrf_pkg::PROTO_RESET);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: setting = itrf_pkg::PROTO_RESET;
        2: setting = 8'd255;
        3: setting = 8'd0;
        default: setting = 8'($urandom_range(0, 255));
      endcase
      write_protocol(setting);
      rx_mode = rx_mode_t'(phase % 3);
      tx_gaps = 1'(phase % 2);
      if (phase == 2) begin
        long_hold = 1'b1;
        send_packet(make_packet(itrf_pkg::VERSION_V4, 4'd5, setting, 60, 16'd60));
      end
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_packet(setting);
    end
    settle();

    $display("Covered %0d packets, %0d bytes, %0d protocol settings, %0d results checked",
             packets_sent, bytes_sent, settings_used, sb.checked);
    $display("Verdicts ok/small/v4/proto/size/hdr/ihl: %0d %0d %0d %0d %0d %0d %0d",
             sb.code_seen[itrf_pkg::ST_OK], sb.code_seen[itrf_pkg::ST_TOO_SMALL],
             sb.code_seen[itrf_pkg::ST_NOT_V4], sb.code_seen[itrf_pkg::ST_BAD_PROTO],
             sb.code_seen[itrf_pkg::ST_BAD_SIZE], sb.code_seen[itrf_pkg::ST_HDR_LONG],
             sb.code_seen[itrf_pkg::ST_BAD_IHL]);
    if (sb.errors == 0 && sb.pending_items.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+hdl
hdl/itrf_pkg.sv
hdl/itrf_parse.sv
hdl/itrf_outq.sv
hdl/ipv4_tcp_receive_filter_top.sv
test/ipv4_tcp_receive_filter_top_tb.sv
